[rtl/core/wrm_pkg.sv]
package wrm_pkg;

  localparam int CHANNELS_DEF    = 2;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int WINDOW_BITS_DEF = 16;

  localparam int IN_W   = 24;
  localparam int RMS_W  = 24;
  localparam int LEN_W  = 16;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 4;

  localparam logic [15:0] WINDOW_RESET   = 16'd12000;
  localparam logic [1:0]  CHANNELS_RESET = 2'd2;

  localparam logic [1:0] REG_ENABLE   = 2'd0;
  localparam logic [1:0] REG_WINDOW   = 2'd1;
  localparam logic [1:0] REG_CHANNELS = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_DIV,
    ST_SQRT,
    ST_OUT
  } wrm_state_t;

  typedef struct packed {
    logic load_in;
    logic acc;
    logic div_load;
    logic div_step;
    logic sqrt_step;
    logic out_load;
  } wrm_cmd_t;

  typedef struct packed {
    logic hit;
    logic out_busy;
  } wrm_sts_t;

endpackage

[rtl/core/wrm_in_if.sv]
interface wrm_in_if import wrm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [IN_W-1:0]  sample_left;
  logic signed [IN_W-1:0]  sample_right;

  modport source (output valid, output sample_left, output sample_right, input ready);
  modport sink   (input valid, input sample_left, input sample_right, output ready);
endinterface

[rtl/core/wrm_out_if.sv]
interface wrm_out_if import wrm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RMS_W-1:0]  rms_left;
  logic [RMS_W-1:0]  rms_right;
  logic [LEN_W-1:0]  window_length;

  modport source (output valid, output rms_left, output rms_right, output window_length,
                  input ready);
  modport sink   (input valid, input rms_left, input rms_right, input window_length,
                  output ready);
endinterface

[rtl/core/windowed_rms_meter.sv]
// Windowed RMS level meter. Takes one stereo Q1.23 frame per request and, while enabled
// with a nonzero window, adds the square of each active channel to a 62-bit sum. A frame
// is taken in one cycle and accumulated in the next, so a new frame is taken only once
// the last is accumulated. When the frame count reaches the window length, the block
// closes the window: a bit-serial restoring divider (one quotient bit per cycle) forms
// sum / count for both channels in parallel, then a digit-by-digit square root (two
// radicand bits per cycle) yields the RMS; input is not taken again until that result
// is loaded, which waits while the previous result is still pending. One result register
// decouples the output side, so new frames are taken while a result waits. Registers:
// enable at 0x0, window length at 0x4, channel count at 0x8 (1 mono, 2 stereo); write
// only while idle.
module windowed_rms_meter import wrm_pkg::*; #(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int WINDOW_BITS = WINDOW_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  wrm_in_if.sink            in_ch,
  wrm_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic                   enable_r;
  logic [WINDOW_BITS-1:0] window_r;
  logic [1:0]             chan_r;
  logic                   cfg_wr;
  logic                   stereo;
  logic                   active;
  logic                   in_ready;
  wrm_cmd_t               cmd;
  wrm_sts_t               sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      window_r <= WINDOW_RESET[WINDOW_BITS-1:0];
      chan_r   <= CHANNELS_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_ENABLE:   enable_r <= pwdata[0];
        REG_WINDOW:   window_r <= pwdata[WINDOW_BITS-1:0];
        REG_CHANNELS: chan_r   <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ENABLE:   prdata = DATA_W'(enable_r);
      REG_WINDOW:   prdata = DATA_W'(window_r);
      REG_CHANNELS: prdata = DATA_W'(chan_r);
      default:      prdata = '0;
    endcase
  end

  assign stereo      = (CHANNELS > 1) && chan_r[1];
  assign active      = enable_r && (window_r != '0);
  assign in_ch.ready = in_ready;

  wrm_ctrl #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .WINDOW_BITS (WINDOW_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .active   (active),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  wrm_datapath #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .WINDOW_BITS (WINDOW_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stereo       (stereo),
    .window       (window_r),
    .sample_left  (in_ch.sample_left),
    .sample_right (in_ch.sample_right),
    .sts          (sts),
    .out_ch       (out_ch)
  );

`ifndef SYNTH
  localparam logic [RMS_W-1:0] RMS_MAX = RMS_W'(1) << (SAMPLE_BITS - 1);

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.window_length != '0)
    else $error("result with zero window length");

  a_rms_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.rms_left <= RMS_MAX) && (out_ch.rms_right <= RMS_MAX))
    else $error("rms out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_ch.valid && !out_ch.ready))
    else $error("pending result overwritten");
`endif

endmodule

[rtl/core/wrm_ctrl.sv]
module wrm_ctrl import wrm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int WINDOW_BITS = WINDOW_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     active,
  input  wrm_sts_t sts,
  output logic     in_ready,
  output wrm_cmd_t cmd
);

  localparam int SUM_W  = 2 * SAMPLE_BITS + WINDOW_BITS - 2;
  localparam int ROOT_W = (SUM_W + 1) / 2;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int STEP_W = $clog2(RAD_W);

  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(RAD_W - 1);
  localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(ROOT_W - 1);

  wrm_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && active) state_nxt = ST_ACC;
      end
      ST_ACC: begin
        step_nxt = '0;
        if (sts.hit) state_nxt = ST_DIV;
        else         state_nxt = ST_IDLE;
      end
      ST_DIV: begin
        if (step_r == DIV_LAST) begin
          state_nxt = ST_SQRT;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      ST_SQRT: begin
        if (step_r == SQRT_LAST) begin
          state_nxt = ST_OUT;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      ST_OUT: begin
        if (!sts.out_busy) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready      = (state_r == ST_IDLE);
    cmd.load_in   = (state_r == ST_IDLE) && in_valid;
    cmd.acc       = (state_r == ST_ACC);
    cmd.div_load  = (state_r == ST_ACC) && sts.hit;
    cmd.div_step  = (state_r == ST_DIV);
    cmd.sqrt_step = (state_r == ST_SQRT);
    cmd.out_load  = (state_r == ST_OUT) && !sts.out_busy;
  end

endmodule

[rtl/core/wrm_datapath.sv]
module wrm_datapath import wrm_pkg::*; #(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int WINDOW_BITS = WINDOW_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  wrm_cmd_t               cmd,
  input  logic                   stereo,
  input  logic [WINDOW_BITS-1:0] window,
  input  logic [IN_W-1:0]        sample_left,
  input  logic [IN_W-1:0]        sample_right,
  output wrm_sts_t               sts,
  wrm_out_if.source              out_ch
);

  localparam int SQ_W   = 2 * SAMPLE_BITS;
  localparam int SUM_W  = 2 * SAMPLE_BITS + WINDOW_BITS - 2;
  localparam int ROOT_W = (SUM_W + 1) / 2;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int SREM_W = ROOT_W + 2;

  logic [SAMPLE_BITS-1:0] samp_l_r, samp_r_r;
  logic                   stereo_r;
  logic [WINDOW_BITS-1:0] count_r, count_inc, n_r;
  logic [ROOT_W-1:0]      root_w [CHANNELS];
  logic [ROOT_W-1:0]      root_right;
  logic                   out_valid_r;
  logic [RMS_W-1:0]       rms_left_r, rms_right_r;
  logic [LEN_W-1:0]       len_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      samp_l_r <= sample_left[SAMPLE_BITS-1:0];
      samp_r_r <= sample_right[SAMPLE_BITS-1:0];
      stereo_r <= stereo;
    end
    if (cmd.div_load) n_r <= count_inc;
  end

  assign count_inc = count_r + WINDOW_BITS'(1);
  assign sts.hit   = (count_inc >= window);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.acc) begin
      count_r <= cmd.div_load ? '0 : count_inc;
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    logic [SAMPLE_BITS-1:0] samp, mag;
    logic [SQ_W-1:0]        sq;
    logic                   lane_en;
    logic [SUM_W-1:0]       sum_r, sum_nxt;
    logic [RAD_W-1:0]       q_r;
    logic [WINDOW_BITS-1:0] drem_r;
    logic [WINDOW_BITS:0]   dtry, ddiff;
    logic [SREM_W-1:0]      srem_r, stry, strial;
    logic [ROOT_W-1:0]      root_r;

    assign samp    = (c == 0) ? samp_l_r : samp_r_r;
    assign mag     = samp[SAMPLE_BITS-1] ? (~samp + SAMPLE_BITS'(1)) : samp;
    assign sq      = SQ_W'(mag) * SQ_W'(mag);
    assign lane_en = (c == 0) || stereo_r;
    assign sum_nxt = lane_en ? (sum_r + SUM_W'(sq)) : sum_r;

    assign dtry   = {drem_r, q_r[RAD_W-1]};
    assign ddiff  = dtry - {1'b0, n_r};
    assign stry   = {srem_r[SREM_W-3:0], q_r[RAD_W-1 -: 2]};
    assign strial = {root_r, 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sum_r <= '0;
      end else if (cmd.acc) begin
        sum_r <= cmd.div_load ? '0 : sum_nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.div_load) begin
        q_r    <= RAD_W'(sum_nxt);
        drem_r <= '0;
        srem_r <= '0;
        root_r <= '0;
      end else if (cmd.div_step) begin
        if (dtry >= {1'b0, n_r}) begin
          drem_r <= ddiff[WINDOW_BITS-1:0];
          q_r    <= {q_r[RAD_W-2:0], 1'b1};
        end else begin
          drem_r <= dtry[WINDOW_BITS-1:0];
          q_r    <= {q_r[RAD_W-2:0], 1'b0};
        end
      end else if (cmd.sqrt_step) begin
        q_r <= {q_r[RAD_W-3:0], 2'b00};
        if (stry >= strial) begin
          srem_r <= stry - strial;
          root_r <= {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          srem_r <= stry;
          root_r <= {root_r[ROOT_W-2:0], 1'b0};
        end
      end
    end

    assign root_w[c] = root_r;
  end

  if (CHANNELS > 1) begin : g_right
    assign root_right = stereo_r ? root_w[1] : '0;
  end else begin : g_mono
    assign root_right = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rms_left_r  <= RMS_W'(root_w[0]);
      rms_right_r <= RMS_W'(root_right);
      len_r       <= LEN_W'(n_r);
    end
  end

  assign sts.out_busy         = out_valid_r && !out_ch.ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.rms_left      = rms_left_r;
  assign out_ch.rms_right     = rms_right_r;
  assign out_ch.window_length = len_r;

endmodule
